FILE: design/rgb_to_hsv_converter_defines.svh
// Assertion macros used by the converter RTL.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RHC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

   localparam int CHANNEL_W     = 8;
   localparam int HUE_W         = 15;
   localparam int SAT_W         = 17;

   localparam int HUE_FRAC_BITS = 6;
   localparam int SAT_FRAC_BITS = 16;

   // One sector (60 degrees) and the full circle in hue units
   localparam int HUE_SIXTY     = 60 << HUE_FRAC_BITS;
   localparam int HUE_FULL      = 360 << HUE_FRAC_BITS;

   // Quotient widths: hue term is at most one sector, saturation at most 1.0
   localparam int HUE_Q_W       = $clog2(HUE_SIXTY + 1);
   localparam int SAT_Q_W       = SAT_FRAC_BITS + 1;
   localparam int QUO_W_A       = (HUE_Q_W > SAT_Q_W) ? HUE_Q_W : SAT_Q_W;
   localparam int QUO_W         = (QUO_W_A > SAT_W) ? QUO_W_A : SAT_W;

   // Dividend stays below divisor * 2^QUO_W, divisor is one channel byte
   localparam int DIVIDEND_W    = QUO_W + CHANNEL_W;

   localparam int STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES    = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // Front stage, product stage, divider stages, output stage
   localparam int PIPE_STAGES   = DIV_STAGES + 3;

   localparam int HUE_CALC_A    = $clog2(HUE_FULL) + 1;
   localparam int HUE_CALC_W    = (HUE_CALC_A > HUE_W + 1) ? HUE_CALC_A : HUE_W + 1;

endpackage

`default_nettype wire

FILE: design/rhc_if.sv
`default_nettype none

// Pixel channel: one red, green, blue byte triple per transfer
interface rhc_req_if import rhc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] red;
   logic [CHANNEL_W-1:0] green;
   logic [CHANNEL_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

// Result channel: one hue, saturation, value triple per transfer
interface rhc_rsp_if import rhc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [HUE_W-1:0]     hue;
   logic [SAT_W-1:0]     saturation;
   logic [CHANNEL_W-1:0] brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

`default_nettype wire

FILE: design/rgb_to_hsv_converter.sv
`default_nettype none
// RGB to HSV converter, fixed point.
//
// req_pixel carries one pixel (red, green, blue bytes) per transfer; rsp_hsv
// returns one result per pixel, in order: hue in 1/64 degree (0 for grey),
// saturation with 65536 meaning 1.0 (0 for black), and brightness, the
// largest channel byte. Both channels transfer when valid and ready are high.
//
// The block is a pipeline of 3 + DIV_STAGES stages (8 at the default
// widths): min/max and sector selection, hue product and divider operands,
// DIV_STAGES divider stages at up to four quotient bits each, and the output
// register. One pixel a clock is sustained while rsp_hsv is ready. The
// divider depth (17 quotient bits, four per stage) sets the pipeline length.
//
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves on, so a stall at rsp_hsv backs up stage by stage,
// bubbles close up, and req_pixel.ready falls only once every stage holds a
// pixel. Synchronous reset empties the pipeline; nothing else is kept.

`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter import rhc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rhc_req_if.sink   req_pixel,
   rhc_rsp_if.source rsp_hsv
);

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   localparam int OUT_STAGE = PIPE_STAGES - 1;

   typedef struct packed {
      logic [1:0]           sector;
      logic                 neg;
      logic [CHANNEL_W-1:0] brightness;
   } side_type;

   // Per-stage valid bits and load enables
   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES:0]   adv;

   // Front stage
   logic [CHANNEL_W-1:0] a_max_ff,    a_max_in;
   logic [CHANNEL_W-1:0] a_chroma_ff, a_chroma_in;
   logic [CHANNEL_W-1:0] a_abs_ff,    a_abs_in;
   logic                 a_neg_ff,    a_neg_in;
   logic [1:0]           a_sector_ff, a_sector_in;

   // Operand stage
   logic [DIVIDEND_W-1:0] b_sat_num_ff, b_sat_num_in;
   logic [DIVIDEND_W-1:0] b_hue_num_ff, b_hue_num_in;
   logic [CHANNEL_W-1:0]  b_sat_den_ff, b_sat_den_in;
   logic [CHANNEL_W-1:0]  b_hue_den_ff, b_hue_den_in;
   side_type              b_side_ff,    b_side_in;

   // Sideband that travels alongside the divider stages
   side_type d_side_ff [DIV_STAGES];

   logic [QUO_W-1:0] sat_quo;
   logic [QUO_W-1:0] hue_quo;

   // Output stage
   logic [HUE_W-1:0]     hue_ff,    hue_in;
   logic [SAT_W-1:0]     sat_ff,    sat_in;
   logic [CHANNEL_W-1:0] bright_ff, bright_in;

   // ---------------------------------------------------------------------
   // Flow control: a stage loads when empty or when its successor loads
   // ---------------------------------------------------------------------
   always_comb begin
      adv[PIPE_STAGES] = rsp_hsv.ready;
      for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_pixel.ready = adv[0];

   always_comb begin
      valid_in = valid_ff;
      for (int k = 0; k < PIPE_STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = (k == 0) ? req_pixel.valid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Front stage: largest and smallest channel, sector, signed difference
   // ---------------------------------------------------------------------
   always_comb begin
      logic [CHANNEL_W-1:0] r, g, b, lo, x, y;
      r = req_pixel.red;
      g = req_pixel.green;
      b = req_pixel.blue;

      // red wins ties, then green
      priority if (r >= g && r >= b) begin
         a_sector_in = SECTOR_RED;
         a_max_in    = r;
         x           = g;
         y           = b;
      end else if (g >= b) begin
         a_sector_in = SECTOR_GREEN;
         a_max_in    = g;
         x           = b;
         y           = r;
      end else begin
         a_sector_in = SECTOR_BLUE;
         a_max_in    = b;
         x           = r;
         y           = g;
      end

      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;

      a_chroma_in = a_max_in - lo;
      a_neg_in    = (x < y);
      a_abs_in    = a_neg_in ? (y - x) : (x - y);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_max_ff    <= a_max_in;
         a_chroma_ff <= a_chroma_in;
         a_abs_ff    <= a_abs_in;
         a_neg_ff    <= a_neg_in;
         a_sector_ff <= a_sector_in;
      end
   end

   // ---------------------------------------------------------------------
   // Operand stage: scale the numerators, keep divisors nonzero
   // ---------------------------------------------------------------------
   // A zero divisor only comes with a zero numerator, so dividing by one
   // gives the required zero for black and grey pixels.
   always_comb begin
      b_hue_num_in = DIVIDEND_W'(a_abs_ff) * DIVIDEND_W'(HUE_SIXTY);
      b_sat_num_in = DIVIDEND_W'(a_chroma_ff) << SAT_FRAC_BITS;
      b_sat_den_in = (a_max_ff == '0)    ? CHANNEL_W'(1) : a_max_ff;
      b_hue_den_in = (a_chroma_ff == '0) ? CHANNEL_W'(1) : a_chroma_ff;
      b_side_in.sector     = a_sector_ff;
      b_side_in.neg        = a_neg_ff;
      b_side_in.brightness = a_max_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         b_hue_num_ff <= b_hue_num_in;
         b_sat_num_ff <= b_sat_num_in;
         b_sat_den_ff <= b_sat_den_in;
         b_hue_den_ff <= b_hue_den_in;
         b_side_ff    <= b_side_in;
      end
   end

   // ---------------------------------------------------------------------
   // Divider stages: saturation and hue quotients side by side
   // ---------------------------------------------------------------------
   rhc_divider u_sat_div (
      .clock    (clock),
      .advance  (adv[2 +: DIV_STAGES]),
      .dividend (b_sat_num_ff),
      .divisor  (b_sat_den_ff),
      .quotient (sat_quo)
   );

   rhc_divider u_hue_div (
      .clock    (clock),
      .advance  (adv[2 +: DIV_STAGES]),
      .dividend (b_hue_num_ff),
      .divisor  (b_hue_den_ff),
      .quotient (hue_quo)
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (adv[2]) d_side_ff[0] <= b_side_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (adv[2+s]) d_side_ff[s] <= d_side_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: add the sector base, wrap negative hues
   // ---------------------------------------------------------------------
   always_comb begin
      logic signed [HUE_CALC_W-1:0] base, term, sum;
      side_type side;
      side = d_side_ff[DIV_STAGES-1];

      unique case (side.sector)
         SECTOR_RED:   base = '0;
         SECTOR_GREEN: base = HUE_CALC_W'(2 * HUE_SIXTY);
         SECTOR_BLUE:  base = HUE_CALC_W'(4 * HUE_SIXTY);
         default:      base = '0;
      endcase

      term = HUE_CALC_W'(hue_quo[HUE_Q_W-1:0]);
      sum  = side.neg ? (base - term) : (base + term);
      if (sum < 0) begin
         sum = sum + HUE_CALC_W'(HUE_FULL);
      end

      hue_in    = sum[HUE_W-1:0];
      sat_in    = sat_quo[SAT_W-1:0];
      bright_in = side.brightness;
   end

   always_ff @(posedge clock) begin
      if (adv[OUT_STAGE]) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= bright_in;
      end
   end

   assign rsp_hsv.valid      = valid_ff[OUT_STAGE];
   assign rsp_hsv.hue        = hue_ff;
   assign rsp_hsv.saturation = sat_ff;
   assign rsp_hsv.brightness = bright_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `RHC_ASSERT_NEXT(a_accept_fills_front, clock, reset, req_pixel.valid && req_pixel.ready, valid_ff[0], "accepted pixel did not enter the front stage")
   `RHC_ASSERT_IMPL(a_black_no_sat, clock, reset, rsp_hsv.valid && rsp_hsv.brightness == '0, rsp_hsv.saturation == '0, "black pixel with nonzero saturation")
   `RHC_ASSERT_IMPL(a_grey_no_hue, clock, reset, rsp_hsv.valid && rsp_hsv.saturation == '0, rsp_hsv.hue == '0, "grey pixel with nonzero hue")
   `RHC_ASSERT_IMPL(a_hue_range, clock, reset, rsp_hsv.valid, 32'(rsp_hsv.hue) < HUE_FULL, "hue beyond full circle")

endmodule

`default_nettype wire

FILE: design/rhc_divider.sv
`default_nettype none

// Pipelined restoring divider, up to STEPS_PER_STAGE quotient bits per stage.
// The caller guarantees quotient < 2^QUO_W and a nonzero divisor.
module rhc_divider import rhc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic [DIV_STAGES-1:0] advance,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [CHANNEL_W-1:0]  divisor,
   output logic      [QUO_W-1:0]      quotient
);

   typedef struct packed {
      logic [CHANNEL_W-1:0] rem;
      logic [QUO_W-1:0]     low;
      logic [QUO_W-1:0]     quo;
   } div_state_type;

   div_state_type        state_ff [DIV_STAGES];
   logic [CHANNEL_W-1:0] den_ff   [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      div_state_type        src;
      div_state_type        state_in;
      logic [CHANNEL_W-1:0] den_src;

      if (s == 0) begin : g_first
         // top bits of the dividend are already below the divisor
         assign src.rem = dividend[DIVIDEND_W-1:QUO_W];
         assign src.low = dividend[QUO_W-1:0];
         assign src.quo = '0;
         assign den_src = divisor;
      end else begin : g_next
         assign src     = state_ff[s-1];
         assign den_src = den_ff[s-1];
      end

      always_comb begin
         logic [CHANNEL_W:0] trial;
         logic               qbit;
         trial    = '0;
         qbit     = 1'b0;
         state_in = src;
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if (s * STEPS_PER_STAGE + j < QUO_W) begin
               trial = {state_in.rem, state_in.low[QUO_W-1]};
               qbit  = (trial >= {1'b0, den_src});
               if (qbit) begin
                  state_in.rem = CHANNEL_W'(trial - {1'b0, den_src});
               end else begin
                  state_in.rem = trial[CHANNEL_W-1:0];
               end
               state_in.low = {state_in.low[QUO_W-2:0], 1'b0};
               state_in.quo = {state_in.quo[QUO_W-2:0], qbit};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance[s]) begin
            state_ff[s] <= state_in;
            den_ff[s]   <= den_src;
         end
      end
   end

   assign quotient = state_ff[DIV_STAGES-1].quo;

endmodule

`default_nettype wire
